/* sv/sorted_priority_queue_with_cursor_core_defines.svh */
// ---------------------------------------------------------------------------
// Assertion macros for the sorted priority queue
// Shared concurrent assertion forms, compiled out with NO_ASSERTIONS.
// ---------------------------------------------------------------------------
`ifndef SORTED_PRIORITY_QUEUE_WITH_CURSOR_CORE_DEFINES_SVH
`define SORTED_PRIORITY_QUEUE_WITH_CURSOR_CORE_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define SPQC_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("spqc assertion failed");
`define SPQC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("spqc assertion failed");
`else
`define SPQC_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define SPQC_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

/* sv/spqc_pkg.sv */
// ---------------------------------------------------------------------------
// Sorted priority queue package
// Word types, mode and status codes shared by the cells and the top level.
// ---------------------------------------------------------------------------
package spqc_pkg;

  localparam logic [1:0] MODE_PUSH  = 2'd0;
  localparam logic [1:0] MODE_POP   = 2'd1;
  localparam logic [1:0] MODE_FIRST = 2'd2;
  localparam logic [1:0] MODE_NEXT  = 2'd3;

  localparam logic [1:0] STATUS_OK   = 2'd0;
  localparam logic [1:0] STATUS_NONE = 2'd1;
  localparam logic [1:0] STATUS_FULL = 2'd2;

  typedef struct packed {
    logic [1:0]         mode;
    logic [15:0]        parent_value;
    logic [15:0]        slot_index;
    logic signed [31:0] weight;
  } in_word_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [15:0]        out_parent;
    logic [15:0]        out_slot;
    logic signed [31:0] out_weight;
    logic               queue_empty;
    logic               browse_done;
    logic               single_entry;
  } out_word_t;

  typedef struct packed {
    logic [15:0]        parent;
    logic [15:0]        slot;
    logic signed [31:0] weight;
  } entry_t;

  typedef struct packed {
    logic   push_en;
    logic   pop_en;
    entry_t new_entry;
  } cell_ctrl_t;

endpackage

/* sv/sorted_priority_queue_with_cursor_core.sv */
// ---------------------------------------------------------------------------
// Sorted priority queue with browse cursor
// A row of cells kept in ascending weight order, with a count and a cursor.
// ---------------------------------------------------------------------------
// The result word is registered, in the cycle after the input word is taken.
// Throughput: one word per cycle; push and pop shift the cell row at most once.
// A waiting result stalls the input only while the output is itself stalled.
// Reset clears the count, the cursor and the output valid flag.
// Cell contents are not reset and are read only below the count.
`include "sorted_priority_queue_with_cursor_core_defines.svh"

module sorted_priority_queue_with_cursor_core #(
  parameter int CAPACITY = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  spqc_pkg::in_word_t   in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output spqc_pkg::out_word_t  out_data
);

  localparam int CNT_W = $clog2(CAPACITY + 1);

  logic [CNT_W-1:0]    count_r;
  logic [CNT_W-1:0]    count_nxt;
  logic [CNT_W-1:0]    bpos_r;
  logic [CNT_W-1:0]    bpos_nxt;
  logic                out_valid_r;
  logic                out_valid_nxt;
  spqc_pkg::out_word_t out_data_r;
  spqc_pkg::out_word_t out_data_nxt;

  logic                accept;
  logic                full;
  logic                empty;
  spqc_pkg::cell_ctrl_t ctrl;
  spqc_pkg::entry_t    cell_entry [CAPACITY];
  logic [CAPACITY-1:0] cell_lt;
  logic [CAPACITY-1:0] cell_sel;
  spqc_pkg::entry_t    cursor_entry;
  logic                cursor_lt;
  spqc_pkg::entry_t    new_entry;

  assign in_stall  = out_valid_r && out_stall;
  assign accept    = in_valid && !in_stall;
  assign full      = (count_r == CNT_W'(CAPACITY));
  assign empty     = (count_r == '0);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign new_entry.parent = in_data.parent_value;
  assign new_entry.slot   = in_data.slot_index;
  assign new_entry.weight = in_data.weight;

  assign ctrl.push_en   = accept && (in_data.mode == spqc_pkg::MODE_PUSH) && !full;
  assign ctrl.pop_en    = accept && (in_data.mode == spqc_pkg::MODE_POP) && !empty;
  assign ctrl.new_entry = new_entry;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic             occ;
    logic             lt_l;
    spqc_pkg::entry_t left_e;
    spqc_pkg::entry_t right_e;

    assign occ         = (CNT_W'(i) < count_r);
    assign cell_sel[i] = (CNT_W'(i) == bpos_r);

    if (i == 0) begin : g_first
      assign lt_l   = 1'b1;
      assign left_e = new_entry;
    end else begin : g_mid
      assign lt_l   = cell_lt[i-1];
      assign left_e = cell_entry[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign right_e = cell_entry[i];
    end else begin : g_inner
      assign right_e = cell_entry[i+1];
    end

    spqc_cell u_cell (
      .clk         (clk),
      .ctrl        (ctrl),
      .occupied    (occ),
      .lt_left     (lt_l),
      .left_entry  (left_e),
      .right_entry (right_e),
      .entry       (cell_entry[i]),
      .lt          (cell_lt[i])
    );
  end

  always_comb begin
    cursor_entry = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      cursor_entry = cursor_entry | (cell_sel[i] ? cell_entry[i] : '0);
    end
    cursor_lt = |(cell_sel & cell_lt);
  end

  always_comb begin
    logic [CNT_W-1:0] b;
    count_nxt    = count_r;
    bpos_nxt     = bpos_r;
    out_data_nxt = '0;
    b            = bpos_r;
    case (in_data.mode)
      spqc_pkg::MODE_PUSH: begin
        if (full) begin
          out_data_nxt.status = spqc_pkg::STATUS_FULL;
        end else begin
          count_nxt = count_r + 1'b1;
          if ((bpos_r >= count_r) || !cursor_lt) begin
            bpos_nxt = bpos_r + 1'b1;
          end
        end
      end
      spqc_pkg::MODE_POP: begin
        if (empty) begin
          out_data_nxt.status = spqc_pkg::STATUS_NONE;
        end else begin
          out_data_nxt.out_parent = cell_entry[0].parent;
          out_data_nxt.out_slot   = cell_entry[0].slot;
          out_data_nxt.out_weight = cell_entry[0].weight;
          count_nxt = count_r - 1'b1;
          if (bpos_r != '0) begin
            bpos_nxt = bpos_r - 1'b1;
          end
        end
      end
      default: begin
        if (in_data.mode == spqc_pkg::MODE_FIRST) begin
          b = '0;
        end
        if (b >= count_r) begin
          bpos_nxt            = count_r;
          out_data_nxt.status = spqc_pkg::STATUS_NONE;
        end else begin
          if (in_data.mode == spqc_pkg::MODE_FIRST) begin
            out_data_nxt.out_parent = cell_entry[0].parent;
            out_data_nxt.out_slot   = cell_entry[0].slot;
            out_data_nxt.out_weight = cell_entry[0].weight;
          end else begin
            out_data_nxt.out_parent = cursor_entry.parent;
            out_data_nxt.out_slot   = cursor_entry.slot;
            out_data_nxt.out_weight = cursor_entry.weight;
          end
          bpos_nxt = b + 1'b1;
        end
      end
    endcase
    out_data_nxt.queue_empty  = (count_nxt == '0);
    out_data_nxt.browse_done  = (bpos_nxt >= count_nxt);
    out_data_nxt.single_entry = (count_nxt == CNT_W'(1));
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (accept) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      bpos_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (accept) begin
        count_r <= count_nxt;
        bpos_r  <= bpos_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data_r <= out_data_nxt;
    end
  end

  `SPQC_ASSERT_SAME(a_count_bound, clk, rst_n, 1'b1, count_r <= CNT_W'(CAPACITY))
  `SPQC_ASSERT_SAME(a_cursor_bound, clk, rst_n, 1'b1, bpos_r <= count_r)
  `SPQC_ASSERT_NEXT(a_full_push_holds, clk, rst_n,
                    accept && (in_data.mode == spqc_pkg::MODE_PUSH) && full,
                    $stable(count_r) && (out_data_r.status == spqc_pkg::STATUS_FULL))
  `SPQC_ASSERT_NEXT(a_pop_shrinks, clk, rst_n, ctrl.pop_en,
                    count_r == $past(count_r) - 1'b1)

endmodule

/* sv/spqc_cell.sv */
// ---------------------------------------------------------------------------
// Sorted queue cell
// Holds one entry; on a push it keeps, takes the new entry or takes its left
// neighbour's, and on a pop it takes its right neighbour's.
// ---------------------------------------------------------------------------
module spqc_cell (
  input  logic                clk,
  input  spqc_pkg::cell_ctrl_t ctrl,
  input  logic                occupied,
  input  logic                lt_left,
  input  spqc_pkg::entry_t    left_entry,
  input  spqc_pkg::entry_t    right_entry,
  output spqc_pkg::entry_t    entry,
  output logic                lt
);

  spqc_pkg::entry_t entry_r;
  spqc_pkg::entry_t entry_nxt;

  assign lt    = occupied && (entry_r.weight < ctrl.new_entry.weight);
  assign entry = entry_r;

  always_comb begin
    entry_nxt = entry_r;
    if (ctrl.push_en) begin
      if (lt) begin
        entry_nxt = entry_r;
      end else if (lt_left) begin
        entry_nxt = ctrl.new_entry;
      end else begin
        entry_nxt = left_entry;
      end
    end else if (ctrl.pop_en) begin
      entry_nxt = right_entry;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

endmodule

/* bench/sorted_priority_queue_with_cursor_core_test.sv */
// ---------------------------------------------------------------------------
// Sorted priority queue with cursor: self-checking test
// Words are driven from a queue with random gaps and results are taken with
// random stalls. A shadow queue predicts every result word, which is
// compared field by field with the word that the block returns.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

module sorted_priority_queue_with_cursor_core_test;

  localparam int DEPTH = 16;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  spqc_pkg::in_word_t  in_data = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  spqc_pkg::out_word_t out_data;

  spqc_pkg::in_word_t  stim_words[$];
  spqc_pkg::out_word_t awaited_words[$];

  spqc_pkg::entry_t    shadow_cells[DEPTH];
  int                  shadow_count = 0;
  int                  shadow_cursor = 0;

  int                  words_sent = 0;
  int                  words_seen = 0;
  int                  send_gap = 0;
  int                  take_hold = 0;
  int                  fault_count = 0;
  bit                  send_free;
  spqc_pkg::out_word_t want;

  sorted_priority_queue_with_cursor_core #(.CAPACITY(DEPTH)) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
  end

  function automatic spqc_pkg::out_word_t queue_model_step(spqc_pkg::in_word_t w);
    spqc_pkg::out_word_t r;
    int                  pos;
    int                  i;
    r = '0;
    r.status = spqc_pkg::STATUS_OK;
    case (w.mode)
      spqc_pkg::MODE_PUSH: begin
        if (shadow_count >= DEPTH) begin
          r.status = spqc_pkg::STATUS_FULL;
        end else begin
          pos = 0;
          while (pos < shadow_count &&
                 $signed(shadow_cells[pos].weight) < $signed(w.weight)) pos++;
          for (i = shadow_count; i > pos; i--) shadow_cells[i] = shadow_cells[i - 1];
          shadow_cells[pos].parent = w.parent_value;
          shadow_cells[pos].slot = w.slot_index;
          shadow_cells[pos].weight = w.weight;
          shadow_count++;
          if (pos <= shadow_cursor) shadow_cursor++;
        end
      end
      spqc_pkg::MODE_POP: begin
        if (shadow_count == 0) begin
          r.status = spqc_pkg::STATUS_NONE;
        end else begin
          r.out_parent = shadow_cells[0].parent;
          r.out_slot = shadow_cells[0].slot;
          r.out_weight = shadow_cells[0].weight;
          for (i = 0; i + 1 < shadow_count; i++) shadow_cells[i] = shadow_cells[i + 1];
          shadow_count--;
          if (shadow_cursor > 0) shadow_cursor--;
        end
      end
      default: begin
        if (w.mode == spqc_pkg::MODE_FIRST) shadow_cursor = 0;
        if (shadow_cursor >= shadow_count) begin
          shadow_cursor = shadow_count;
          r.status = spqc_pkg::STATUS_NONE;
        end else begin
          r.out_parent = shadow_cells[shadow_cursor].parent;
          r.out_slot = shadow_cells[shadow_cursor].slot;
          r.out_weight = shadow_cells[shadow_cursor].weight;
          shadow_cursor++;
        end
      end
    endcase
    r.queue_empty = (shadow_count == 0);
    r.browse_done = (shadow_cursor >= shadow_count);
    r.single_entry = (shadow_count == 1);
    return r;
  endfunction

  function automatic int draw_wait(int done);
    if ((done / 150) % 4 == 1) return 0;
    return $urandom_range(0, 1) ? 0 : $urandom_range(0, 13);
  endfunction

  function automatic logic [31:0] pick_weight();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2, 3: return $urandom_range(0, 4) - 2;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [15:0] pick_field();
    case ($urandom_range(0, 7))
      0: return 16'h0000;
      1: return 16'hffff;
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  task automatic add_word(logic [1:0] mode, logic [15:0] parent, logic [15:0] slot,
                          logic [31:0] weight);
    spqc_pkg::in_word_t w;
    w.mode = mode;
    w.parent_value = parent;
    w.slot_index = slot;
    w.weight = weight;
    stim_words.push_back(w);
  endtask

  initial begin
    int kind;
    int span;
    int roll;
    logic [1:0] mode;

    add_word(spqc_pkg::MODE_POP, 16'h0000, 16'h0000, 32'h0);
    add_word(spqc_pkg::MODE_FIRST, 16'hffff, 16'hffff, 32'hffff_ffff);
    add_word(spqc_pkg::MODE_NEXT, 16'h0000, 16'h0000, 32'h0);
    add_word(spqc_pkg::MODE_PUSH, 16'hffff, 16'h0000, 32'h7fff_ffff);
    add_word(spqc_pkg::MODE_PUSH, 16'h0000, 16'hffff, 32'h8000_0000);
    add_word(spqc_pkg::MODE_PUSH, 16'h1234, 16'h5678, 32'h0);
    add_word(spqc_pkg::MODE_PUSH, 16'haaaa, 16'h5555, 32'h0);
    add_word(spqc_pkg::MODE_FIRST, 16'h0000, 16'h0000, 32'h0);
    add_word(spqc_pkg::MODE_NEXT, 16'h0000, 16'h0000, 32'h0);
    add_word(spqc_pkg::MODE_PUSH, 16'h0f0f, 16'hf0f0, 32'hffff_fffb);
    add_word(spqc_pkg::MODE_NEXT, 16'h0000, 16'h0000, 32'h0);
    add_word(spqc_pkg::MODE_POP, 16'h0000, 16'h0000, 32'h0);
    add_word(spqc_pkg::MODE_FIRST, 16'h0000, 16'h0000, 32'h0);
    add_word(spqc_pkg::MODE_POP, 16'h0000, 16'h0000, 32'h0);
    add_word(spqc_pkg::MODE_NEXT, 16'h0000, 16'h0000, 32'h0);
    add_word(spqc_pkg::MODE_NEXT, 16'h0000, 16'h0000, 32'h0);
    add_word(spqc_pkg::MODE_NEXT, 16'h0000, 16'h0000, 32'h0);
    add_word(spqc_pkg::MODE_NEXT, 16'h0000, 16'h0000, 32'h0);
    add_word(spqc_pkg::MODE_PUSH, 16'h8001, 16'h7ffe, 32'h7fff_ffff);
    add_word(spqc_pkg::MODE_NEXT, 16'h0000, 16'h0000, 32'h0);
    add_word(spqc_pkg::MODE_FIRST, 16'h0000, 16'h0000, 32'h0);

    while (stim_words.size() < 1320) begin
      kind = $urandom_range(0, 3);
      span = $urandom_range(20, 60);
      repeat (span) begin
        roll = $urandom_range(0, 99);
        case (kind)
          0: mode = (roll < 75) ? spqc_pkg::MODE_PUSH : 2'($urandom_range(1, 3));
          1: mode = (roll < 60) ? spqc_pkg::MODE_POP :
                    (roll < 80) ? spqc_pkg::MODE_PUSH : 2'($urandom_range(2, 3));
          2: mode = (roll < 10) ? spqc_pkg::MODE_FIRST :
                    (roll < 60) ? spqc_pkg::MODE_NEXT :
                    (roll < 80) ? spqc_pkg::MODE_PUSH : spqc_pkg::MODE_POP;
          default: mode = 2'($urandom_range(0, 3));
        endcase
        add_word(mode, pick_field(), pick_field(), pick_weight());
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      send_gap <= 0;
    end else begin
      send_free = !in_valid || !in_stall;
      if (in_valid && !in_stall) begin
        awaited_words.push_back(queue_model_step(in_data));
        words_sent++;
      end
      if (send_free) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
          in_valid <= 1'b0;
        end else if (stim_words.size() > 0) begin
          in_data <= stim_words.pop_front();
          in_valid <= 1'b1;
          send_gap <= draw_wait(words_sent);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      take_hold = 0;
    end else begin
      if (out_valid && !out_stall) begin
        words_seen++;
        if (awaited_words.size() == 0) begin
          fault_count++;
          if (fault_count <= 10)
            $display("Result word with none expected: %p", out_data);
        end else begin
          want = awaited_words.pop_front();
          if (want.status !== out_data.status ||
              want.out_parent !== out_data.out_parent ||
              want.out_slot !== out_data.out_slot ||
              want.out_weight !== out_data.out_weight ||
              want.queue_empty !== out_data.queue_empty ||
              want.browse_done !== out_data.browse_done ||
              want.single_entry !== out_data.single_entry) begin
            fault_count++;
            if (fault_count <= 10)
              $display("Result word %0d differs: expected %p, got %p",
                       words_seen, want, out_data);
          end
        end
        take_hold = draw_wait(words_seen);
      end
      if (take_hold > 0) begin
        out_stall <= 1'b1;
        take_hold = take_hold - 1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  initial begin
    @(posedge rst_n);
    @(negedge clk);
    while (stim_words.size() > 0 || in_valid || awaited_words.size() > 0) @(negedge clk);
    repeat (20) @(negedge clk);
    if (fault_count == 0 && awaited_words.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule

/* sorted_priority_queue_with_cursor_core.f */
+incdir+sv
sv/spqc_pkg.sv
sv/spqc_cell.sv
sv/sorted_priority_queue_with_cursor_core.sv
bench/sorted_priority_queue_with_cursor_core_test.sv
